// ===== sv/gec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gec_pkg: shared types and constants of the gradient edge classifier
// entry layout, direction codes, register indexes and threshold settings
// ----------------------------------------------------------------------------
package gec_pkg;

    localparam int MAG_BITS = 12;
    localparam logic [MAG_BITS-1:0] MAG_MAX = 12'hFFF;

    // tan(22.5 deg) ~ TAN_NUM / 2^TAN_SHIFT
    localparam int TAN_NUM   = 106;
    localparam int TAN_SHIFT = 8;

    localparam int OUT_BITS    = 1 + 10 + 10;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [1:0] {
        DIR_H = 2'd0,
        DIR_D = 2'd1,
        DIR_V = 2'd2,
        DIR_A = 2'd3
    } dir_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_TLOW   = 3'd1,
        CFG_THIGH  = 3'd2,
        CFG_WIDTH  = 3'd3,
        CFG_HEIGHT = 3'd4
    } cfg_index_t;

    localparam logic MODE_HYST = 1'b0;
    localparam logic MODE_NMS  = 1'b1;

    // one line store / window entry, direction in the top bits
    typedef struct packed {
        dir_t                dir;
        logic [MAG_BITS-1:0] mag;
    } entry_t;

    typedef struct packed {
        logic                mode;
        logic [MAG_BITS-1:0] thr_lo;
        logic [MAG_BITS-1:0] thr_hi;
    } thr_cfg_t;

endpackage

// ===== sv/gradient_edge_classifier_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_edge_classifier_3x3: streaming 3x3 edge classifier on gradients
// line-buffered window of L1 magnitude and direction, one decision per pixel
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake                | payload
//  ----------+-----+--------------------------+---------------------------------
//  s_*       | in  | s_tvalid / s_tready      | grad_x, grad_y (signed)
//  m_*       | out | m_tvalid / m_tready      | edge_res, out_row, out_col
//  cfg_*     | in  | cfg_we (always taken)    | cfg_index selects, cfg_data
//
//  one pixel word per clock sustained while results are taken; a word's decision
//  reaches the result register through the input reg, window reg and result reg
//  the line store read port sets the first stage: reads are registered
//  pixels in row 0 or column 0 produce no result word; each result belongs
//  to the pixel one row up and one column left of the incoming one
//  rst_n clears counters, window and valid bits; line stores are not cleared
//  a held result stalls the whole pipe; s_tready follows the result register
// ----------------------------------------------------------------------------
module gradient_edge_classifier_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int GRAD_BITS  = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // slave side
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // grad_x, grad_y
    input  logic [((2*GRAD_BITS+7)/8)*8-1:0]   s_tdata,
    // master side
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // edge_res, out_row, out_col
    output logic [gec_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [gec_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gec_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DW = 14;   // room for clamped sizes up to 4096 and +1

    typedef struct packed {
        logic       emit;
        logic       inner;
        logic [9:0] row;
        logic [9:0] col;
    } pix_tag_t;

    // configuration registers
    logic                         mode_reg;
    logic [gec_pkg::MAG_BITS-1:0] thr_lo_reg;
    logic [gec_pkg::MAG_BITS-1:0] thr_hi_reg;
    logic [10:0]                  width_reg;
    logic [10:0]                  height_reg;
    gec_pkg::thr_cfg_t            thr_cfg;

    // frame position
    logic [CW-1:0] col_cnt_reg;
    logic [CW-1:0] col_cnt_next;
    logic [RW-1:0] row_cnt_reg;
    logic [RW-1:0] row_cnt_next;
    logic [DW-1:0] width_lim;
    logic [DW-1:0] height_lim;
    logic          col_wrap;
    pix_tag_t      tag_in;

    // pipeline
    logic                   advance;
    logic                   accept;
    logic                   a_valid_reg;
    logic [GRAD_BITS-1:0]   a_gx_reg;
    logic [GRAD_BITS-1:0]   a_gy_reg;
    logic [CW-1:0]          a_col_reg;
    pix_tag_t               a_tag_reg;
    logic                   b_valid_reg;
    pix_tag_t               b_tag_reg;
    gec_pkg::entry_t [8:0]  win_reg;
    gec_pkg::entry_t [8:0]  win_next;
    gec_pkg::entry_t        now_entry;
    gec_pkg::entry_t        upper_rd;
    gec_pkg::entry_t        middle_rd;
    logic                   edge_bit;
    logic                   res_valid_reg;
    logic                   res_edge_reg;
    logic [9:0]             res_row_reg;
    logic [9:0]             res_col_reg;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= gec_pkg::MODE_HYST;
            thr_lo_reg <= 12'd216;
            thr_hi_reg <= 12'd218;
            width_reg  <= 11'd160;
            height_reg <= 11'd160;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gec_pkg::CFG_MODE:   mode_reg   <= cfg_data[0];
                gec_pkg::CFG_TLOW:   thr_lo_reg <= cfg_data;
                gec_pkg::CFG_THIGH:  thr_hi_reg <= cfg_data;
                gec_pkg::CFG_WIDTH:  width_reg  <= cfg_data[10:0];
                gec_pkg::CFG_HEIGHT: height_reg <= cfg_data[10:0];
                default: ;   // unused indexes are dropped
            endcase
        end
    end

    assign thr_cfg.mode   = mode_reg;
    assign thr_cfg.thr_lo = thr_lo_reg;
    assign thr_cfg.thr_hi = thr_hi_reg;

    // ------------------------------------------------------------------
    // raster counters, clamped frame size
    // ------------------------------------------------------------------
    always_comb
    begin
        if (DW'(width_reg) < DW'(3))
            width_lim = DW'(3);
        else if (DW'(width_reg) > DW'(MAX_WIDTH))
            width_lim = DW'(MAX_WIDTH);
        else
            width_lim = DW'(width_reg);

        if (DW'(height_reg) < DW'(3))
            height_lim = DW'(3);
        else if (DW'(height_reg) > DW'(MAX_HEIGHT))
            height_lim = DW'(MAX_HEIGHT);
        else
            height_lim = DW'(height_reg);

        col_wrap = (DW'(col_cnt_reg) + DW'(1)) >= width_lim;
        if (col_wrap)
        begin
            col_cnt_next = '0;
            if ((DW'(row_cnt_reg) + DW'(1)) >= height_lim)
                row_cnt_next = '0;
            else
                row_cnt_next = RW'(row_cnt_reg + RW'(1));
        end
        else
        begin
            col_cnt_next = CW'(col_cnt_reg + CW'(1));
            row_cnt_next = row_cnt_reg;
        end

        // decided pixel sits one row up and one column left
        tag_in.emit  = (row_cnt_reg != '0) && (col_cnt_reg != '0);
        tag_in.inner = (row_cnt_reg >= RW'(2)) && (col_cnt_reg >= CW'(2));
        tag_in.row   = 10'(RW'(row_cnt_reg - RW'(1)));
        tag_in.col   = 10'(CW'(col_cnt_reg - CW'(1)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (accept)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: every stage moves when the result slot frees
    // ------------------------------------------------------------------
    assign advance  = !res_valid_reg || m_tready;
    assign accept   = s_tvalid && advance;
    assign s_tready = advance;

    // stage a: input word, line store read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (advance)
            a_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_gx_reg  <= s_tdata[GRAD_BITS-1:0];
            a_gy_reg  <= s_tdata[2*GRAD_BITS-1:GRAD_BITS];
            a_col_reg <= col_cnt_reg;
            a_tag_reg <= tag_in;
        end
    end

    gec_grad_prep #(
        .GRAD_BITS (GRAD_BITS)
    ) u_prep (
        .grad_x (a_gx_reg),
        .grad_y (a_gy_reg),
        .entry  (now_entry)
    );

    gec_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr   (col_cnt_reg),
        .wr_en     (advance && a_valid_reg),
        .wr_addr   (a_col_reg),
        .wr_entry  (now_entry),
        .upper_rd  (upper_rd),
        .middle_rd (middle_rd)
    );

    // stage b: window shifts left, new column enters on the right
    always_comb
    begin
        win_next = win_reg;
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = upper_rd;
        win_next[5] = middle_rd;
        win_next[8] = now_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            win_reg     <= '0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid_reg;
            if (a_valid_reg)
                win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && a_valid_reg)
            b_tag_reg <= a_tag_reg;
    end

    gec_decide u_decide (
        .win      (win_reg),
        .cfg      (thr_cfg),
        .edge_bit (edge_bit)
    );

    // result register; border centers report background
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= b_valid_reg && b_tag_reg.emit;
    end

    always_ff @(posedge clk)
    begin
        if (advance && b_valid_reg)
        begin
            res_edge_reg <= b_tag_reg.inner && edge_bit;
            res_row_reg  <= b_tag_reg.row;
            res_col_reg  <= b_tag_reg.col;
        end
    end

    assign m_tvalid = res_valid_reg;

    always_comb
    begin
        m_tdata        = '0;
        m_tdata[0]     = res_edge_reg;
        m_tdata[10:1]  = res_row_reg;
        m_tdata[20:11] = res_col_reg;
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (col_cnt_reg == '0) ||
                   (col_cnt_reg == CW'($past(col_cnt_reg) + CW'(1))))
        else $error("column counter skipped");

    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !col_wrap) |=> $stable(row_cnt_reg))
        else $error("row counter moved inside a row");

    a_inner_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_tag_reg.inner) |-> b_tag_reg.emit)
        else $error("interior pixel without result word");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && b_valid_reg && b_tag_reg.emit) |=> res_valid_reg)
        else $error("decided pixel lost before result register");

    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> a_valid_reg)
        else $error("accepted word not in input stage");

endmodule

// ===== sv/gec_grad_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gec_grad_prep: magnitude and direction of one gradient pixel
// saturated L1 magnitude and 4-way direction code by tan(22.5 deg) compares
// ----------------------------------------------------------------------------
module gec_grad_prep #(
    parameter int GRAD_BITS = 12
) (
    input  logic [GRAD_BITS-1:0] grad_x,
    input  logic [GRAD_BITS-1:0] grad_y,
    output gec_pkg::entry_t      entry
);

    localparam int SW = (GRAD_BITS + 1 > gec_pkg::MAG_BITS + 1) ?
                        GRAD_BITS + 1 : gec_pkg::MAG_BITS + 1;
    localparam int PW = GRAD_BITS + gec_pkg::TAN_SHIFT;

    logic                 neg_x;
    logic                 neg_y;
    logic [GRAD_BITS-1:0] abs_x;
    logic [GRAD_BITS-1:0] abs_y;
    logic [SW-1:0]        sum;
    logic [PW-1:0]        y_scaled;
    logic [PW-1:0]        x_scaled;
    logic [PW-1:0]        x_tan;
    logic [PW-1:0]        y_tan;

    always_comb
    begin
        neg_x = grad_x[GRAD_BITS-1];
        neg_y = grad_y[GRAD_BITS-1];
        // most negative value maps onto itself, read as unsigned
        abs_x = neg_x ? GRAD_BITS'(~grad_x + GRAD_BITS'(1)) : grad_x;
        abs_y = neg_y ? GRAD_BITS'(~grad_y + GRAD_BITS'(1)) : grad_y;

        sum = SW'(abs_x) + SW'(abs_y);
        if (sum > SW'(gec_pkg::MAG_MAX))
            entry.mag = gec_pkg::MAG_MAX;
        else
            entry.mag = sum[gec_pkg::MAG_BITS-1:0];

        y_scaled = PW'(abs_y) << gec_pkg::TAN_SHIFT;
        x_scaled = PW'(abs_x) << gec_pkg::TAN_SHIFT;
        x_tan    = PW'(abs_x) * PW'(gec_pkg::TAN_NUM);
        y_tan    = PW'(abs_y) * PW'(gec_pkg::TAN_NUM);

        priority if (y_scaled <= x_tan)
            entry.dir = gec_pkg::DIR_H;
        else if (x_scaled <= y_tan)
            entry.dir = gec_pkg::DIR_V;
        else if (neg_x == neg_y)
            entry.dir = gec_pkg::DIR_D;
        else
            entry.dir = gec_pkg::DIR_A;
    end

endmodule

// ===== sv/gec_line_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gec_line_buf: two line stores of entries with registered reads
// upper row takes the middle row's old entry, middle row takes the new one
// ----------------------------------------------------------------------------
module gec_line_buf #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  gec_pkg::entry_t          wr_entry,
    output gec_pkg::entry_t          upper_rd,
    output gec_pkg::entry_t          middle_rd
);

    gec_pkg::entry_t upper_mem  [DEPTH];
    gec_pkg::entry_t middle_mem [DEPTH];
    gec_pkg::entry_t upper_rd_reg;
    gec_pkg::entry_t middle_rd_reg;

    // read data stays put until the next read, so a stalled word keeps it
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            upper_rd_reg  <= upper_mem[rd_addr];
            middle_rd_reg <= middle_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= middle_rd_reg;
            middle_mem[wr_addr] <= wr_entry;
        end
    end

    assign upper_rd  = upper_rd_reg;
    assign middle_rd = middle_rd_reg;

endmodule

// ===== sv/gec_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gec_decide: edge decision on a 3x3 window of entries
// hysteresis test or non-maximum suppression along the center direction
// ----------------------------------------------------------------------------
module gec_decide (
    input  gec_pkg::entry_t [8:0] win,
    input  gec_pkg::thr_cfg_t     cfg,
    output logic                  edge_bit
);

    logic [gec_pkg::MAG_BITS-1:0] center;
    logic [gec_pkg::MAG_BITS-1:0] side_a;
    logic [gec_pkg::MAG_BITS-1:0] side_b;
    logic                         strong_nbr;
    logic                         hyst_edge;
    logic                         nms_edge;

    always_comb
    begin
        center = win[4].mag;

        strong_nbr = 1'b0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4 && win[i].mag >= cfg.thr_hi)
                strong_nbr = 1'b1;
        end

        priority if (center >= cfg.thr_hi)
            hyst_edge = 1'b1;
        else if (center < cfg.thr_lo)
            hyst_edge = 1'b0;
        else
            hyst_edge = strong_nbr;

        // window index = 3*row + col, row 2 is the newest line
        unique case (win[4].dir)
            gec_pkg::DIR_H:
            begin
                side_a = win[3].mag;
                side_b = win[5].mag;
            end
            gec_pkg::DIR_D:
            begin
                side_a = win[8].mag;
                side_b = win[0].mag;
            end
            gec_pkg::DIR_V:
            begin
                side_a = win[7].mag;
                side_b = win[1].mag;
            end
            gec_pkg::DIR_A:
            begin
                side_a = win[6].mag;
                side_b = win[2].mag;
            end
            default:
            begin
                side_a = win[6].mag;
                side_b = win[2].mag;
            end
        endcase

        nms_edge = (side_a < center) && (side_b < center);
        edge_bit = (cfg.mode == gec_pkg::MODE_NMS) ? nms_edge : hyst_edge;
    end

endmodule
